@@ rtl/core/tvbt_pkg.sv @@
// Package for the tunnel/view binding table.
// Holds the request and status codes used by the core.
package tvbt_pkg;
  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_READ   = 3'd3,
    REQ_LOOKUP = 3'd4
  } req_e;

  localparam logic [0:0] STATUS_OK  = 1'b0;
  localparam logic [0:0] STATUS_ERR = 1'b1;
endpackage

@@ rtl/core/tunnel_view_binding_table.sv @@
// Tunnel/view binding table: one request in, one result out, on stream channels.
// Throughput: one request at a time. Lookup, read and view-range errors are
// answered from the first table read. The rest of an add reads the reverse table
// and the owner's entry, after which a no-op add or a view-in-use error is answered.
// Add and delete then walk the sorted list in one memory, one entry per cycle:
// the search stops at the entry's position; a new binding or a found delete
// then runs the shift pass from there to the end, and a changed binding is
// rewritten in place. The bound count is at most VIEW_ID_MAX. Clear, and reset,
// sweep both tables with a clearing pass, during which no request is taken (a
// clear request is answered when the pass ends); configuration writes are taken
// at any time.
// Depends on tvbt_pkg.
module tunnel_view_binding_table #(
  parameter int TUNNEL_ID_MAX = 4095,
  parameter int VIEW_ID_MAX   = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] req_type, [14:3] tunnel_id, [24:15] view_id_in, [34:25] list_position
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] status, [12:1] tunnel_id_out, [22:13] view_id_out, [33:23] bound_count
  output logic [39:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tvbt_pkg::*;

  localparam int NT = TUNNEL_ID_MAX + 1;
  localparam int NV = VIEW_ID_MAX + 1;
  localparam int TW = $clog2(NT);
  localparam int VW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);
  localparam int SW = (NT > NV) ? TW : VW;

  // state codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;  // t2v[t] and sorted[pos] pending
  localparam logic [3:0] S_RD2   = 4'd3;  // v2t[v] pending
  localparam logic [3:0] S_RD3   = 4'd4;  // t2v[owner] pending
  localparam logic [3:0] S_SRCH  = 4'd5;  // scan sorted list
  localparam logic [3:0] S_SHUP  = 4'd6;  // shift toward higher index
  localparam logic [3:0] S_SHDN  = 4'd7;  // shift toward lower index
  localparam logic [3:0] S_OUT   = 4'd8;

  // APB
  logic [9:0] min_view_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {22'd0, min_view_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_view_q <= 10'd1;
    else if (psel && penable && pwrite && pready && paddr == 2'd0) min_view_q <= pwdata[9:0];
  end

  // memories
  logic [VW-1:0] t2v_mem [NT];
  logic [TW-1:0] v2t_mem [NV];
  logic [TW+VW-1:0] srt_mem [NV];
  logic [TW-1:0] t2v_ra, t2v_wa;  logic [VW-1:0] t2v_wd, t2v_rd; logic t2v_we;
  logic [VW-1:0] v2t_ra, v2t_wa;  logic [TW-1:0] v2t_wd, v2t_rd; logic v2t_we;
  logic [VW-1:0] srt_ra, srt_wa;  logic [TW+VW-1:0] srt_wd, srt_rd; logic srt_we;
  always_ff @(posedge clk_i) begin
    if (t2v_we) t2v_mem[t2v_wa] <= t2v_wd;
    t2v_rd <= t2v_mem[t2v_ra];
    if (v2t_we) v2t_mem[v2t_wa] <= v2t_wd;
    v2t_rd <= v2t_mem[v2t_ra];
    if (srt_we) srt_mem[srt_wa] <= srt_wd;
    srt_rd <= srt_mem[srt_ra];
  end

  logic [3:0] st_q, st_d;
  logic [SW:0] clr_q, clr_d;
  logic [2:0] req_q, req_d;
  logic [11:0] tin_q, tin_d;
  logic [9:0] vin_q, vin_d;
  logic [9:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] old_q, old_d;      // tunnel's current view
  logic [CW-1:0] idx_q, idx_d;      // walk index
  logic [TW+VW-1:0] hold_q, hold_d; // entry carried along the shift
  logic          ov_q, ov_d;
  logic [39:0]   out_q, out_d;

  wire tun_ok = ({20'd0, tin_q} <= 32'(TUNNEL_ID_MAX));
  wire [TW-1:0] tin_t = tin_q[TW-1:0];
  wire [TW-1:0] srt_t = srt_rd[TW+VW-1:VW];

  function automatic logic [39:0] pack(logic s, logic [11:0] t, logic [9:0] v,
                                       logic [10:0] c);
    pack = {6'd0, c, v, t, s};
  endfunction

  assign s_axis_tready_o = (st_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = out_q;
  wire in_acc = s_axis_tvalid_i && s_axis_tready_o;

  logic [10:0] cnt11;
  assign cnt11 = 11'(cnt_q);

  always_comb begin
    st_d = st_q; clr_d = clr_q; req_d = req_q; tin_d = tin_q; vin_d = vin_q;
    pos_d = pos_q; cnt_d = cnt_q; old_d = old_q; idx_d = idx_q;
    hold_d = hold_q; out_d = out_q;
    ov_d = ov_q && !m_axis_tready_i;
    t2v_we = 1'b0; t2v_wa = '0; t2v_wd = '0; t2v_ra = tin_t;
    v2t_we = 1'b0; v2t_wa = '0; v2t_wd = '0; v2t_ra = vin_q[VW-1:0];
    srt_we = 1'b0; srt_wa = '0; srt_wd = '0; srt_ra = pos_q[VW-1:0];
    unique case (st_q)
      S_CLR: begin
        t2v_we = ({1'b0, clr_q} < (SW+1)'(NT)) ; t2v_wa = clr_q[TW-1:0];
        v2t_we = ({1'b0, clr_q} < (SW+1)'(NV)) ; v2t_wa = clr_q[VW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (SW+1)'((NT > NV ? NT : NV) - 1)) begin
          st_d = S_IDLE;
          if (req_q == REQ_CLEAR) begin
            out_d = pack(STATUS_OK, tin_q, 10'd0, 11'd0); ov_d = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_d = s_axis_tdata_i[2:0];  tin_d = s_axis_tdata_i[14:3];
          vin_d = s_axis_tdata_i[24:15]; pos_d = s_axis_tdata_i[34:25];
          t2v_ra = s_axis_tdata_i[3 +: TW];
          srt_ra = s_axis_tdata_i[25 +: VW];
          v2t_ra = s_axis_tdata_i[15 +: VW];
          if (s_axis_tdata_i[2:0] == REQ_CLEAR) begin
            st_d = S_CLR; clr_d = '0; cnt_d = '0;
          end else st_d = S_RD1;
        end
      end
      S_RD1: begin
        old_d = t2v_rd;
        st_d = S_OUT;
        case (req_q)
          REQ_ADD: begin
            if (!tun_ok) out_d = pack(STATUS_ERR, tin_q, 10'd0, cnt11);
            else if (vin_q == 10'd0 || vin_q < min_view_q ||
                     {22'd0, vin_q} > 32'(VIEW_ID_MAX))
              out_d = pack(STATUS_ERR, tin_q, 10'(t2v_rd), cnt11);
            else st_d = S_RD2;
          end
          REQ_DELETE: begin
            if (!tun_ok) out_d = pack(STATUS_ERR, tin_q, 10'd0, cnt11);
            else if (t2v_rd == '0) out_d = pack(STATUS_OK, tin_q, 10'd0, cnt11);
            else begin
              t2v_we = 1'b1; t2v_wa = tin_t; t2v_wd = '0;
              v2t_we = 1'b1; v2t_wa = t2v_rd; v2t_wd = '0;
              idx_d = '0; srt_ra = '0; st_d = S_SRCH;
            end
          end
          REQ_READ: begin
            if ({1'b0, pos_q} >= 11'(cnt_q) || {22'd0, pos_q} >= 32'(NV))
              out_d = pack(STATUS_ERR, tin_q, 10'd0, cnt11);
            else out_d = pack(STATUS_OK, 12'(srt_t), 10'(srt_rd[VW-1:0]), cnt11);
          end
          REQ_LOOKUP: begin
            if (!tun_ok) out_d = pack(STATUS_ERR, tin_q, 10'd0, cnt11);
            else out_d = pack(STATUS_OK, tin_q, 10'(t2v_rd), cnt11);
          end
          default: out_d = pack(STATUS_ERR, tin_q, 10'd0, cnt11);
        endcase
        if (st_d == S_OUT) ov_d = 1'b1;
      end
      S_RD2: begin
        // v2t_rd valid; fetch t2v[owner]
        t2v_ra = v2t_rd; hold_d = {v2t_rd, {VW{1'b0}}};
        st_d = S_RD3;
      end
      S_RD3: begin
        st_d = S_OUT; ov_d = 1'b1;
        if (t2v_rd == vin_q[VW-1:0] && hold_q[TW+VW-1:VW] != tin_t)
          out_d = pack(STATUS_ERR, tin_q, 10'(old_q), cnt11);
        else if (old_q == vin_q[VW-1:0])
          out_d = pack(STATUS_OK, tin_q, vin_q, cnt11);
        else begin
          t2v_we = 1'b1; t2v_wa = tin_t; t2v_wd = vin_q[VW-1:0];
          if (old_q != '0) begin
            // write new reverse entry via the read cycle: old cleared now,
            // new written in the walk's first cycle
            v2t_we = 1'b1; v2t_wa = old_q; v2t_wd = '0;
          end else begin
            v2t_we = 1'b1; v2t_wa = vin_q[VW-1:0]; v2t_wd = tin_t;
          end
          if (old_q == '0 && {1'b0, cnt_q} >= (CW+1)'(NV)) begin
            out_d = pack(STATUS_OK, tin_q, vin_q, cnt11);
          end else begin
            ov_d = 1'b0; idx_d = '0; srt_ra = '0; st_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // srt_rd holds entry idx_q
        if (req_q == REQ_ADD && old_q != '0) begin
          v2t_we = 1'b1; v2t_wa = vin_q[VW-1:0]; v2t_wd = tin_t;
        end
        if (idx_q == cnt_q || srt_t >= tin_t) begin
          if (req_q == REQ_ADD && old_q != '0) begin
            srt_we = (idx_q != cnt_q); srt_wa = idx_q[VW-1:0];
            srt_wd = {tin_t, vin_q[VW-1:0]};
            out_d = pack(STATUS_OK, tin_q, vin_q, cnt11); ov_d = 1'b1; st_d = S_OUT;
          end else if (req_q == REQ_ADD) begin
            hold_d = {tin_t, vin_q[VW-1:0]};
            st_d = S_SHUP; srt_ra = idx_q[VW-1:0];
          end else begin
            if (idx_q != cnt_q && srt_t == tin_t) begin
              idx_d = idx_q + 1'b1; srt_ra = VW'(idx_q + 1'b1); st_d = S_SHDN;
            end else begin
              out_d = pack(STATUS_OK, tin_q, 10'd0, cnt11); ov_d = 1'b1; st_d = S_OUT;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1; srt_ra = VW'(idx_q + 1'b1);
        end
      end
      S_SHUP: begin
        // srt_rd holds old entry at idx_q; write carried entry there
        srt_we = 1'b1; srt_wa = idx_q[VW-1:0]; srt_wd = hold_q;
        hold_d = srt_rd;
        if (idx_q == cnt_q) begin
          cnt_d = cnt_q + 1'b1;
          out_d = pack(STATUS_OK, tin_q, vin_q, 11'(cnt_q + 1'b1));
          ov_d = 1'b1; st_d = S_OUT;
        end else begin
          idx_d = idx_q + 1'b1; srt_ra = VW'(idx_q + 1'b1);
        end
      end
      S_SHDN: begin
        // srt_rd holds entry idx_q (when below count); move it to idx_q-1
        if (idx_q == cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          out_d = pack(STATUS_OK, tin_q, 10'd0, 11'(cnt_q - 1'b1));
          ov_d = 1'b1; st_d = S_OUT;
        end else begin
          srt_we = 1'b1; srt_wa = VW'(idx_q - 1'b1); srt_wd = srt_rd;
          idx_d = idx_q + 1'b1; srt_ra = VW'(idx_q + 1'b1);
        end
      end
      S_OUT: begin
        if (!ov_q) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; cnt_q <= '0; ov_q <= 1'b0; req_q <= REQ_ADD;
    end else begin
      st_q <= st_d; clr_q <= clr_d; cnt_q <= cnt_d; ov_q <= ov_d; req_q <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tin_q <= tin_d; vin_q <= vin_d; pos_q <= pos_d; old_q <= old_d;
    idx_q <= idx_d; hold_q <= hold_d; out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (CW+1)'(NV)) else $error("bound count overflow");
  a_noacc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !s_axis_tready_o) else $error("accept while busy");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(st_q) == S_SHUP || $past(st_q) == S_SHDN
      || $past(st_q) == S_IDLE)) else $error("count moved outside shift");
`endif
endmodule
